/* sv/mcse_pkg.sv */
// Shared types, constants and helpers for the MIDI controller scan encoder.
// No dependencies; every other file imports this package.
package mcse_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int NUM_POTS    = 4;
    localparam int NUM_CHAN    = NUM_BUTTONS + NUM_POTS;
    localparam int CHAN_W      = $clog2(NUM_CHAN);
    localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int POT_IDX_W   = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;
    localparam int SLIDER_IDX  = NUM_POTS - 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] CFG_MIDI_CHANNEL      = 3'd0;
    localparam logic [2:0] CFG_BUTTON_CC_BASE    = 3'd1;
    localparam logic [2:0] CFG_BUTTON_NOTE_BASE  = 3'd2;
    localparam logic [2:0] CFG_POT_CC_BASE       = 3'd3;
    localparam logic [2:0] CFG_BLINK_INTERVAL_MS = 3'd4;

    // USB-MIDI code indexes and status bytes
    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [3:0] CIN_CTRL     = 4'hB;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CTRL     = 8'hB0;

    localparam logic [10:0] POT_FULL  = 11'd1023;
    localparam logic [6:0]  VALUE_MAX = 7'd127;

    typedef struct packed {
        logic [4:0]  midi_channel;
        logic [6:0]  button_cc_base;
        logic [6:0]  button_note_base;
        logic [6:0]  pot_cc_base;
        logic [15:0] blink_interval_ms;
    } cfg_t;

    // One classified scan, handed from front to back
    typedef struct packed {
        logic                          func;
        logic                          led;
        logic [6:0]                    vel;
        logic [NUM_BUTTONS-1:0]        pressed;
        logic [NUM_CHAN-1:0]           mask;
        logic [NUM_POTS-1:0][6:0]      pot_val;
    } scan_entry_t;

    // raw*127/1023, truncated: shift gives the quotient estimate, one
    // compare fixes it since the remainder stays below twice 1023
    function automatic logic [6:0] scale_pot(input logic [9:0] raw);
        logic [16:0] prod;
        logic [6:0]  q0;
        logic [10:0] rem;
        prod = {raw, 7'b0} - {7'b0, raw};
        q0   = prod[16:10];
        rem  = {1'b0, prod[9:0]} + {4'b0, q0};
        if (rem >= POT_FULL) begin
            q0 = q0 + 7'd1;
        end
        return q0;
    endfunction

endpackage

/* sv/mcse_front.sv */
// Front end: registers a scan, scales pots, compares against sent values,
// updates sent state and LED blink state, and pushes a change mask. Uses mcse_pkg.
module mcse_front
    import mcse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func_pressed,
    input  logic [3:0]          s_button_levels,
    input  logic [9:0]          s_pot_level_0,
    input  logic [9:0]          s_pot_level_1,
    input  logic [9:0]          s_pot_level_2,
    input  logic [9:0]          s_slider_level,
    input  logic [31:0]         s_now_ms,
    input  logic                q_full,
    output logic                q_push,
    output scan_entry_t         q_entry
);

    logic                   scan_vld_reg, scan_vld_next;
    logic                   func_reg;
    logic [3:0]             levels_reg;
    logic [3:0][9:0]        pot_raw_reg;
    logic [31:0]            now_reg;

    logic [NUM_BUTTONS-1:0] sent_btn_reg, sent_btn_next;
    logic [NUM_POTS-1:0][6:0] sent_pot_reg, sent_pot_next;
    logic [31:0]            last_blink_reg, last_blink_next;
    logic                   phase_reg, phase_next;
    logic                   led_reg, led_next;

    logic [NUM_POTS-1:0][6:0] pot_now;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] btn_chg;
    logic [NUM_POTS-1:0]    pot_chg;
    logic [31:0]            elapsed;
    logic                   s_xfer;

    assign q_push  = scan_vld_reg && !q_full;
    assign s_ready = !scan_vld_reg || q_push;
    assign s_xfer  = s_valid && s_ready;
    assign elapsed = now_reg - last_blink_reg;

    always_comb begin
        for (int i = 0; i < NUM_POTS; i++) begin
            pot_now[i] = scale_pot(pot_raw_reg[i]);
        end
        pressed = ~levels_reg[NUM_BUTTONS-1:0];
        btn_chg = pressed ^ sent_btn_reg;
        for (int i = 0; i < NUM_POTS; i++) begin
            pot_chg[i] = (pot_now[i] != sent_pot_reg[i]);
        end
        // slider is the velocity source in function mode, never sent there
        if (func_reg) begin
            pot_chg[SLIDER_IDX] = 1'b0;
        end
    end

    always_comb begin
        scan_vld_next   = scan_vld_reg;
        sent_btn_next   = sent_btn_reg;
        sent_pot_next   = sent_pot_reg;
        last_blink_next = last_blink_reg;
        phase_next      = phase_reg;
        led_next        = led_reg;
        if (q_push) begin
            scan_vld_next = 1'b0;
            sent_btn_next = pressed;
            for (int i = 0; i < NUM_POTS; i++) begin
                if (pot_chg[i]) begin
                    sent_pot_next[i] = pot_now[i];
                end
            end
            if (func_reg) begin
                if (elapsed >= {16'b0, cfg.blink_interval_ms}) begin
                    last_blink_next = now_reg;
                    led_next        = phase_reg;
                    phase_next      = !phase_reg;
                end
            end else begin
                led_next = 1'b0;
            end
        end
        if (s_xfer) begin
            scan_vld_next = 1'b1;
        end
    end

    always_comb begin
        q_entry.func    = func_reg;
        q_entry.led     = led_next;
        q_entry.vel     = (pot_now[SLIDER_IDX] == 7'd0) ? VALUE_MAX : pot_now[SLIDER_IDX];
        q_entry.pressed = pressed;
        q_entry.mask    = {pot_chg, btn_chg};
        q_entry.pot_val = pot_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_vld_reg   <= 1'b0;
            sent_btn_reg   <= '0;
            sent_pot_reg   <= '0;
            last_blink_reg <= '0;
            phase_reg      <= 1'b1;
            led_reg        <= 1'b0;
        end else begin
            scan_vld_reg   <= scan_vld_next;
            sent_btn_reg   <= sent_btn_next;
            sent_pot_reg   <= sent_pot_next;
            last_blink_reg <= last_blink_next;
            phase_reg      <= phase_next;
            led_reg        <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            func_reg       <= s_func_pressed;
            levels_reg     <= s_button_levels;
            pot_raw_reg[0] <= s_pot_level_0;
            pot_raw_reg[1] <= s_pot_level_1;
            pot_raw_reg[2] <= s_pot_level_2;
            pot_raw_reg[3] <= s_slider_level;
            now_reg        <= s_now_ms;
        end
    end

endmodule

/* sv/mcse_queue.sv */
// Short queue of classified scans between front and back end.
// Uses scan_entry_t from mcse_pkg.
module mcse_queue
    import mcse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  scan_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output scan_entry_t head
);

    scan_entry_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]        count_reg, count_next;
    logic                     do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* sv/mcse_back.sv */
// Back end: walks the change mask of one scan, one packet per cycle while m_ready does
// not stall the output, into the output register. Uses mcse_pkg.
module mcse_back
    import mcse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_not_empty,
    input  scan_entry_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_packet_valid,
    output logic [3:0]  m_code_index,
    output logic [7:0]  m_status_byte,
    output logic [6:0]  m_data_first,
    output logic [6:0]  m_data_second,
    output logic        m_led_on,
    output logic        m_last_of_scan
);

    logic                work_vld_reg, work_vld_next;
    scan_entry_t         work_reg;
    logic [NUM_CHAN-1:0] mask_reg, mask_next;

    logic                out_vld_reg, out_vld_next;
    logic                pkt_vld_reg;
    logic [3:0]          cin_reg;
    logic [7:0]          status_reg;
    logic [6:0]          d1_reg, d2_reg;
    logic                led_reg, last_reg;

    logic                emit, last;
    logic [CHAN_W-1:0]   idx;
    logic [NUM_CHAN-1:0] mask_rest;
    logic [3:0]          chan;
    logic [BTN_W-1:0]    btn;
    logic [POT_IDX_W-1:0] pot;
    logic                btn_down;
    logic                pkt_vld;
    logic [3:0]          cin;
    logic [7:0]          status;
    logic [6:0]          d1, d2;

    assign emit      = work_vld_reg && (!out_vld_reg || m_ready);
    assign mask_rest = mask_reg & (mask_reg - 1'b1);
    assign last      = (mask_rest == '0);
    assign q_pop     = q_not_empty && (!work_vld_reg || (emit && last));
    assign chan      = cfg.midi_channel[3:0] - 4'd1;

    // lowest pending channel goes first
    always_comb begin
        idx = '0;
        for (int i = NUM_CHAN - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                idx = CHAN_W'(i);
            end
        end
    end

    always_comb begin
        btn      = BTN_W'(idx);
        pot      = POT_IDX_W'(idx - CHAN_W'(NUM_BUTTONS));
        btn_down = work_reg.pressed[btn];
        pkt_vld  = (mask_reg != '0);
        cin      = CIN_CTRL;
        status   = STATUS_CTRL | {4'h0, chan};
        d1       = '0;
        d2       = '0;
        if (!pkt_vld) begin
            cin    = '0;
            status = '0;
        end else if (idx < CHAN_W'(NUM_BUTTONS)) begin
            if (work_reg.func) begin
                cin    = btn_down ? CIN_NOTE_ON : CIN_NOTE_OFF;
                status = (btn_down ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'h0, chan};
                d1     = cfg.button_note_base + 7'(btn);
                d2     = work_reg.vel;
            end else begin
                d1 = cfg.button_cc_base + 7'(btn);
                d2 = btn_down ? VALUE_MAX : 7'd0;
            end
        end else begin
            d1 = cfg.pot_cc_base + 7'(pot);
            d2 = work_reg.pot_val[pot];
        end
    end

    always_comb begin
        work_vld_next = work_vld_reg;
        mask_next     = mask_reg;
        out_vld_next  = out_vld_reg;
        if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b0;
        end
        if (emit) begin
            out_vld_next = 1'b1;
            mask_next    = mask_rest;
            if (last) begin
                work_vld_next = 1'b0;
            end
        end
        if (q_pop) begin
            work_vld_next = 1'b1;
            mask_next     = q_head.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            work_vld_reg <= work_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
        if (q_pop) begin
            work_reg <= q_head;
        end
        if (emit) begin
            pkt_vld_reg <= pkt_vld;
            cin_reg     <= cin;
            status_reg  <= status;
            d1_reg      <= d1;
            d2_reg      <= d2;
            led_reg     <= work_reg.led;
            last_reg    <= last;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_packet_valid = pkt_vld_reg;
    assign m_code_index   = cin_reg;
    assign m_status_byte  = status_reg;
    assign m_data_first   = d1_reg;
    assign m_data_second  = d2_reg;
    assign m_led_on       = led_reg;
    assign m_last_of_scan = last_reg;

endmodule

/* sv/midi_controller_scan_encoder.sv */
// Top level of the MIDI controller scan encoder: configuration registers,
// front end, scan queue and back end. Uses mcse_pkg, mcse_front, mcse_queue, mcse_back.
//
//  port group   dir  handshake        contents
//  s_*          in   s_valid/s_ready  one scan: function level, buttons, pots, time
//  m_*          out  m_valid/m_ready  one USB-MIDI packet or empty marker, LED, last flag
//  cfg_*        in   cfg_wr_en        register index and write data, no read-back
//
// The front end takes one scan per cycle while the queue is not full and classifies it into a two-entry queue.
// The back end sends one packet per cycle while m_ready does not stall it, one packet per
// changed channel of a scan, at least one and at most eight.
// Reset is synchronous, active low; sent values, blink state and registers return
// to their defaults. A stall on m_ready fills the queue, then holds s_ready low.
module midi_controller_scan_encoder
    import mcse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func_pressed,
    input  logic [3:0]  s_button_levels,
    input  logic [9:0]  s_pot_level_0,
    input  logic [9:0]  s_pot_level_1,
    input  logic [9:0]  s_pot_level_2,
    input  logic [9:0]  s_slider_level,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_packet_valid,
    output logic [3:0]  m_code_index,
    output logic [7:0]  m_status_byte,
    output logic [6:0]  m_data_first,
    output logic [6:0]  m_data_second,
    output logic        m_led_on,
    output logic        m_last_of_scan
);

    cfg_t        cfg_reg, cfg_next;
    logic        q_push, q_full, q_pop, q_not_empty;
    scan_entry_t q_in, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIDI_CHANNEL:      cfg_next.midi_channel      = cfg_wdata[4:0];
                CFG_BUTTON_CC_BASE:    cfg_next.button_cc_base    = cfg_wdata[6:0];
                CFG_BUTTON_NOTE_BASE:  cfg_next.button_note_base  = cfg_wdata[6:0];
                CFG_POT_CC_BASE:       cfg_next.pot_cc_base       = cfg_wdata[6:0];
                CFG_BLINK_INTERVAL_MS: cfg_next.blink_interval_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.midi_channel      <= 5'd16;
            cfg_reg.button_cc_base    <= 7'd102;
            cfg_reg.button_note_base  <= 7'd36;
            cfg_reg.pot_cc_base       <= 7'd106;
            cfg_reg.blink_interval_ms <= 16'd250;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mcse_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func_pressed  (s_func_pressed),
        .s_button_levels (s_button_levels),
        .s_pot_level_0   (s_pot_level_0),
        .s_pot_level_1   (s_pot_level_1),
        .s_pot_level_2   (s_pot_level_2),
        .s_slider_level  (s_slider_level),
        .s_now_ms        (s_now_ms),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_in)
    );

    mcse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    mcse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packet_valid (m_packet_valid),
        .m_code_index   (m_code_index),
        .m_status_byte  (m_status_byte),
        .m_data_first   (m_data_first),
        .m_data_second  (m_data_second),
        .m_led_on       (m_led_on),
        .m_last_of_scan (m_last_of_scan)
    );

endmodule

/* bench/scan_packet_checker.sv */
// Packet checker for the MIDI controller scan encoder bench: predicts the packets of each
// accepted scan and compares them with what the result channel delivers.
// Depends on mcse_pkg for codes, register indexes and channel counts.
module scan_packet_checker
    import mcse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func_pressed,
    input  logic [3:0]  s_button_levels,
    input  logic [9:0]  s_pot_level_0,
    input  logic [9:0]  s_pot_level_1,
    input  logic [9:0]  s_pot_level_2,
    input  logic [9:0]  s_slider_level,
    input  logic [31:0] s_now_ms,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_packet_valid,
    input  logic [3:0]  m_code_index,
    input  logic [7:0]  m_status_byte,
    input  logic [6:0]  m_data_first,
    input  logic [6:0]  m_data_second,
    input  logic        m_led_on,
    input  logic        m_last_of_scan,
    output int unsigned mismatch_count,
    output int unsigned packets_pending
);

    typedef struct packed {
        logic       packet_valid;
        logic [3:0] code_index;
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       led_on;
        logic       last_of_scan;
    } midi_packet_t;

    // register copies
    logic [4:0]  reg_channel;
    logic [6:0]  reg_button_cc;
    logic [6:0]  reg_note_base;
    logic [6:0]  reg_pot_cc;
    logic [15:0] reg_blink_ms;

    // encoder state
    logic                 sent_pressed [NUM_BUTTONS];
    logic [6:0]           sent_level [NUM_POTS];
    logic [31:0]          blink_stamp;
    logic                 blink_phase;
    logic                 led_level;

    midi_packet_t packets_due [$];
    midi_packet_t seen;
    midi_packet_t want;

    function automatic logic [6:0] pot_to_value(input logic [9:0] raw);
        int unsigned product;
        product = int'(raw) * 127;
        return 7'(product / 1023);
    endfunction

    function automatic midi_packet_t make_packet(input logic [3:0] code, input logic [7:0] status,
                                                 input logic [6:0] first, input logic [6:0] second);
        midi_packet_t pkt;
        pkt = '0;
        pkt.packet_valid = 1'b1;
        pkt.code_index   = code;
        pkt.status_byte  = status;
        pkt.data_first   = first;
        pkt.data_second  = second;
        pkt.led_on       = led_level;
        return pkt;
    endfunction

    function automatic string describe(input midi_packet_t p);
        return $sformatf("valid=%0b cin=%h status=%h first=%0d second=%0d led=%0b last=%0b",
                         p.packet_valid, p.code_index, p.status_byte, p.data_first,
                         p.data_second, p.led_on, p.last_of_scan);
    endfunction

    function automatic void encode_scan(input logic func, input logic [3:0] levels,
                                        input logic [9:0] p0, input logic [9:0] p1,
                                        input logic [9:0] p2, input logic [9:0] p3,
                                        input logic [31:0] now);
        midi_packet_t batch [NUM_CHAN];
        logic [6:0]   scaled [NUM_POTS];
        logic [6:0]   vel;
        logic [3:0]   chan;
        logic         pressed;
        int           n;
        int           pot_count;
        n    = 0;
        chan = 4'(reg_channel - 5'd1);
        if (func) begin
            // toggle only once the interval has elapsed, modulo 2^32
            if (now - blink_stamp >= {16'd0, reg_blink_ms}) begin
                blink_stamp = now;
                led_level   = blink_phase;
                blink_phase = !blink_phase;
            end
        end else begin
            led_level = 1'b0;
        end
        scaled[0] = pot_to_value(p0);
        scaled[1] = pot_to_value(p1);
        scaled[2] = pot_to_value(p2);
        scaled[3] = pot_to_value(p3);
        vel = (scaled[SLIDER_IDX] == 7'd0) ? VALUE_MAX : scaled[SLIDER_IDX];
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            pressed = !levels[i];
            if (pressed != sent_pressed[i]) begin
                if (func && pressed) begin
                    batch[n] = make_packet(CIN_NOTE_ON, STATUS_NOTE_ON | {4'd0, chan},
                                           reg_note_base + 7'(i), vel);
                end else if (func) begin
                    batch[n] = make_packet(CIN_NOTE_OFF, STATUS_NOTE_OFF | {4'd0, chan},
                                           reg_note_base + 7'(i), vel);
                end else begin
                    batch[n] = make_packet(CIN_CTRL, STATUS_CTRL | {4'd0, chan},
                                           reg_button_cc + 7'(i), pressed ? VALUE_MAX : 7'd0);
                end
                sent_pressed[i] = pressed;
                n++;
            end
        end
        // the slider is velocity only while in note mode
        pot_count = func ? NUM_POTS - 1 : NUM_POTS;
        for (int i = 0; i < pot_count; i++) begin
            if (scaled[i] != sent_level[i]) begin
                batch[n] = make_packet(CIN_CTRL, STATUS_CTRL | {4'd0, chan},
                                       reg_pot_cc + 7'(i), scaled[i]);
                sent_level[i] = scaled[i];
                n++;
            end
        end
        if (n == 0) begin
            batch[0]        = '0;
            batch[0].led_on = led_level;
            n = 1;
        end
        batch[n-1].last_of_scan = 1'b1;
        for (int k = 0; k < n; k++) begin
            packets_due.push_back(batch[k]);
        end
    endfunction

    initial begin
        mismatch_count  = 0;
        packets_pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_channel   = 5'd16;
            reg_button_cc = 7'd102;
            reg_note_base = 7'd36;
            reg_pot_cc    = 7'd106;
            reg_blink_ms  = 16'd250;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                sent_pressed[i] = 1'b0;
            end
            for (int i = 0; i < NUM_POTS; i++) begin
                sent_level[i] = 7'd0;
            end
            blink_stamp = 32'd0;
            blink_phase = 1'b1;
            led_level   = 1'b0;
            packets_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MIDI_CHANNEL:      reg_channel   = cfg_wdata[4:0];
                    CFG_BUTTON_CC_BASE:    reg_button_cc = cfg_wdata[6:0];
                    CFG_BUTTON_NOTE_BASE:  reg_note_base = cfg_wdata[6:0];
                    CFG_POT_CC_BASE:       reg_pot_cc    = cfg_wdata[6:0];
                    CFG_BLINK_INTERVAL_MS: reg_blink_ms  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                encode_scan(s_func_pressed, s_button_levels, s_pot_level_0, s_pot_level_1,
                            s_pot_level_2, s_slider_level, s_now_ms);
            end
            if (m_valid && m_ready) begin
                seen = {m_packet_valid, m_code_index, m_status_byte, m_data_first,
                        m_data_second, m_led_on, m_last_of_scan};
                if (packets_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected packet: %s", $time, describe(seen));
                    end
                end else begin
                    want = packets_due.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: packet mismatch\n  expected %s\n  actual   %s",
                                     $time, describe(want), describe(seen));
                        end
                    end
                end
            end
        end
        packets_pending = packets_due.size();
    end

endmodule

/* bench/midi_controller_scan_encoder_tb.sv */
// Top of the MIDI controller scan encoder bench: clock, reset, register writes, scan
// stimulus and result back-pressure. Depends on mcse_pkg, scan_packet_checker and the block.
module midi_controller_scan_encoder_tb
    import mcse_pkg::*;
();

    localparam int CYCLE_LIMIT       = 600000;
    localparam int HOLD_OFF_CYCLES   = 400;
    localparam int ITEMS_PER_SETTING = 54;
    localparam int SETTINGS_COUNT    = 5;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [2:0]  cfg_addr        = CFG_MIDI_CHANNEL;
    logic [15:0] cfg_wdata       = 16'd0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_func_pressed  = 1'b0;
    logic [3:0]  s_button_levels = 4'hF;
    logic [9:0]  s_pot_level_0   = 10'd0;
    logic [9:0]  s_pot_level_1   = 10'd0;
    logic [9:0]  s_pot_level_2   = 10'd0;
    logic [9:0]  s_slider_level  = 10'd0;
    logic [31:0] s_now_ms        = 32'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_packet_valid;
    logic [3:0]  m_code_index;
    logic [7:0]  m_status_byte;
    logic [6:0]  m_data_first;
    logic [6:0]  m_data_second;
    logic        m_led_on;
    logic        m_last_of_scan;

    int unsigned mismatch_count;
    int unsigned packets_pending;
    bit          hold_off_req = 1'b0;
    int          quiet_items  = 0;

    // current control positions for the random walk
    logic        held_func;
    logic [3:0]  held_levels;
    logic [9:0]  held_pots [NUM_POTS];
    logic [31:0] clock_ms;

    midi_controller_scan_encoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func_pressed  (s_func_pressed),
        .s_button_levels (s_button_levels),
        .s_pot_level_0   (s_pot_level_0),
        .s_pot_level_1   (s_pot_level_1),
        .s_pot_level_2   (s_pot_level_2),
        .s_slider_level  (s_slider_level),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_valid  (m_packet_valid),
        .m_code_index    (m_code_index),
        .m_status_byte   (m_status_byte),
        .m_data_first    (m_data_first),
        .m_data_second   (m_data_second),
        .m_led_on        (m_led_on),
        .m_last_of_scan  (m_last_of_scan)
    );

    scan_packet_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func_pressed  (s_func_pressed),
        .s_button_levels (s_button_levels),
        .s_pot_level_0   (s_pot_level_0),
        .s_pot_level_1   (s_pot_level_1),
        .s_pot_level_2   (s_pot_level_2),
        .s_slider_level  (s_slider_level),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_valid  (m_packet_valid),
        .m_code_index    (m_code_index),
        .m_status_byte   (m_status_byte),
        .m_data_first    (m_data_first),
        .m_data_second   (m_data_second),
        .m_led_on        (m_led_on),
        .m_last_of_scan  (m_last_of_scan),
        .mismatch_count  (mismatch_count),
        .packets_pending (packets_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic pause_sender();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (quiet_items > 0) begin
            quiet_items--;
        end else if (pick < 4) begin
            quiet_items = $urandom_range(10, 30);
        end else if (pick < 9) begin
            gap = $urandom_range(10, 40);
        end else if (pick < 40) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_scan(input logic func, input logic [3:0] levels,
                             input logic [9:0] p0, input logic [9:0] p1,
                             input logic [9:0] p2, input logic [9:0] p3,
                             input logic [31:0] now);
        @(negedge aclk);
        s_func_pressed  <= func;
        s_button_levels <= levels;
        s_pot_level_0   <= p0;
        s_pot_level_1   <= p1;
        s_pot_level_2   <= p2;
        s_slider_level  <= p3;
        s_now_ms        <= now;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pause_sender();
    endtask

    // drop valid and wait until every predicted packet has been taken
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (packets_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] addr, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic load_regs(input logic [4:0] chan, input logic [6:0] button_cc,
                             input logic [6:0] note_base, input logic [6:0] pot_cc,
                             input logic [15:0] blink_ms);
        put_reg(CFG_MIDI_CHANNEL, {11'd0, chan});
        put_reg(CFG_BUTTON_CC_BASE, {9'd0, button_cc});
        put_reg(CFG_BUTTON_NOTE_BASE, {9'd0, note_base});
        put_reg(CFG_POT_CC_BASE, {9'd0, pot_cc});
        put_reg(CFG_BLINK_INTERVAL_MS, blink_ms);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly small moves of the controls; now and then a scan of pure noise
    task automatic random_scan();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            held_func   = 1'($urandom_range(0, 1));
            held_levels = 4'($urandom);
            for (int i = 0; i < NUM_POTS; i++) begin
                held_pots[i] = 10'($urandom);
            end
            clock_ms = $urandom;
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                held_func = !held_func;
            end
            if ($urandom_range(0, 1) == 0) begin
                held_levels ^= 4'($urandom_range(1, 15));
            end
            for (int i = 0; i < NUM_POTS; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    case ($urandom_range(0, 3))
                        0: held_pots[i] = 10'($urandom);
                        1: begin
                            v = int'(held_pots[i]) + int'($urandom_range(0, 40)) - 20;
                            if (v < 0) v = 0;
                            if (v > 1023) v = 1023;
                            held_pots[i] = 10'(v);
                        end
                        2: held_pots[i] = 10'd0;
                        default: held_pots[i] = 10'd1023;
                    endcase
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                clock_ms += $urandom;
            end else begin
                clock_ms += $urandom_range(0, 600);
            end
        end
        send_scan(held_func, held_levels, held_pots[0], held_pots[1], held_pots[2],
                  held_pots[3], clock_ms);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall_left;
        int calm;
        int pick;
        bit hold_done;
        stall_left = 0;
        calm       = 0;
        hold_done  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) begin
                        calm = $urandom_range(20, 80);
                    end else if (pick < 6) begin
                        stall_left = $urandom_range(20, 60);
                    end else if (pick < 30) begin
                        stall_left = $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed scans under the reset settings
        send_scan(1'b0, 4'hF, 10'd0, 10'd0, 10'd0, 10'd0, 32'd0);           // nothing moved
        send_scan(1'b0, 4'h0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'd10); // all eight
        send_scan(1'b0, 4'h0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'd15);
        send_scan(1'b0, 4'hF, 10'd0, 10'd1, 10'd2, 10'd1022, 32'd20);
        send_scan(1'b1, 4'hA, 10'd0, 10'd1, 10'd2, 10'd0, 32'd300);         // slider zero
        send_scan(1'b1, 4'h5, 10'd0, 10'd1, 10'd2, 10'd8, 32'd400);         // interval not up
        send_scan(1'b1, 4'hF, 10'd0, 10'd1, 10'd2, 10'd9, 32'd550);         // interval exact
        send_scan(1'b1, 4'h0, 10'd512, 10'd8, 10'd9, 10'd1023, 32'd549);    // time went back
        send_scan(1'b0, 4'hF, 10'd512, 10'd8, 10'd9, 10'd1023, 32'd0);      // slider sent again
        send_scan(1'b0, 4'hE, 10'd1022, 10'd8, 10'd9, 10'd9, 32'd1);
        send_scan(1'b1, 4'h7, 10'd1022, 10'd1023, 10'd0, 10'd300, 32'hFFFF_FFFF);
        send_scan(1'b1, 4'h7, 10'd1022, 10'd1023, 10'd0, 10'd300, 32'd0);   // counter wrapped
        send_scan(1'b1, 4'h3, 10'd700, 10'd1023, 10'd0, 10'd0, 32'h8000_0000);
        send_scan(1'b0, 4'hF, 10'd0, 10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF);
        drain_block();

        held_func   = 1'b0;
        held_levels = 4'hF;
        for (int i = 0; i < NUM_POTS; i++) begin
            held_pots[i] = 10'd0;
        end
        clock_ms = 32'd1000;

        for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
            case (setting)
                0: load_regs(5'd1, 7'd0, 7'd0, 7'd0, 16'd1);
                1: load_regs(5'd16, 7'd127, 7'd127, 7'd127, 16'hFFFF); // numbers wrap
                2: load_regs(5'd0, 7'd125, 7'd124, 7'd126, 16'd0);      // channel wraps
                3: load_regs(5'd17, 7'($urandom), 7'($urandom), 7'($urandom),
                             16'($urandom_range(1, 400)));
                default: load_regs(5'd31, 7'($urandom), 7'($urandom), 7'($urandom),
                                   16'($urandom));
            endcase
            if (setting == 0) begin
                hold_off_req = 1'b1;
            end
            repeat (ITEMS_PER_SETTING) random_scan();
            drain_block();
        end

        if (mismatch_count == 0 && packets_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
